### rtl/sva_pkg.sv
// Shared types and constants of the synthesizer voice allocator.
package sva_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } sva_state_t;

  localparam logic [1:0] MODE_ON  = 2'd0;
  localparam logic [1:0] MODE_OFF = 2'd1;
  localparam logic [1:0] MODE_ALL = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_TRIG = 2'd1;
  localparam logic [1:0] ACT_REL  = 2'd2;
  localparam logic [1:0] ACT_MASK = 2'd3;

  localparam logic [1:0] POL_ROUND  = 2'd0;
  localparam logic [1:0] POL_OLDEST = 2'd1;
  localparam logic [1:0] POL_LOW    = 2'd2;
  localparam logic [1:0] POL_HIGH   = 2'd3;

  localparam logic [7:0] NO_NOTE  = 8'd255;
  localparam logic [6:0] TOP_NOTE = 7'd127;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } sva_cmd_t;

  typedef struct packed {
    logic scan_last;
  } sva_sts_t;

endpackage

### rtl/sva_ctrl.sv
// Controller state machine of the voice allocator: input, scan, commit and output valid.
module sva_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  sva_pkg::sva_sts_t sts,
  output sva_pkg::sva_cmd_t cmd
);

  sva_pkg::sva_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sva_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      sva_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sva_pkg::ST_SCAN;
        end
      end
      sva_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = sva_pkg::ST_COMMIT;
        end
      end
      sva_pkg::ST_COMMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sva_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/sva_dp.sv
// Datapath of the voice allocator: lane notes, recency order, lane scan and result register.
module sva_dp #(
  parameter int LANES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_wdata,
  input  sva_pkg::sva_cmd_t                 cmd,
  output sva_pkg::sva_sts_t                 sts,
  input  logic [sva_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [1:0]                        in_tuser,
  output logic [sva_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                        out_tuser
);

  localparam int LW = $clog2(LANES);
  localparam logic [7:0] LANE_MASK = (LANES >= 8) ? 8'hFF : 8'((1 << LANES) - 1);

  logic [7:0]    lane_note_r [LANES];
  logic [LW-1:0] rec_r [LANES];
  logic [LW-1:0] rec_nxt [LANES];
  logic [LW-1:0] rot_r;
  logic [1:0]    policy_r;
  logic [LW-1:0] idx_r;

  logic [1:0]    mode_r;
  logic [6:0]    note_r;
  logic [6:0]    vel_r;
  logic [7:0]    busy_r;

  logic          hit_f_r, idle_f_r, lo_f_r, hi_f_r;
  logic [LW-1:0] hit_l_r, idle_l_r, lo_l_r, hi_l_r;
  logic [6:0]    lo_t_r, hi_t_r;
  logic [LW-1:0] cand_l_r;
  logic [7:0]    cand_n_r;

  logic [sva_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]                     out_user_r;

  logic [LW-1:0] rot_inc;
  logic [7:0]    cur_note;
  logic [7:0]    idx_ext;
  logic          cur_busy;

  logic          steal;
  logic [LW-1:0] st_lane;
  logic [7:0]    st_note;
  logic [LW-1:0] sel_lane;
  logic [7:0]    lane_ext;
  logic          seen;
  logic [LANES-1:0] shift;

  logic [2:0]    res_lane;
  logic [1:0]    res_act;
  logic [7:0]    res_mask;
  logic [6:0]    res_note;
  logic [6:0]    res_vel;
  logic          res_stolen;
  logic [6:0]    res_snote;

  assign rot_inc  = (rot_r == LW'(LANES - 1)) ? '0 : rot_r + 1'b1;
  assign cur_note = lane_note_r[idx_r];
  assign idx_ext  = 8'(idx_r);
  assign cur_busy = (idx_ext < 8'd8) && busy_r[idx_ext[2:0]];
  assign sts.scan_last = (idx_r == LW'(LANES - 1));

  always_comb begin
    st_lane = cand_l_r;
    st_note = cand_n_r;
    case (policy_r)
      sva_pkg::POL_LOW: begin
        st_lane = lo_f_r ? lo_l_r : '0;
        st_note = lo_f_r ? {1'b0, lo_t_r} : sva_pkg::NO_NOTE;
      end
      sva_pkg::POL_HIGH: begin
        st_lane = hi_f_r ? hi_l_r : '0;
        st_note = hi_f_r ? {1'b0, hi_t_r} : sva_pkg::NO_NOTE;
      end
      default: begin
        st_lane = cand_l_r;
        st_note = cand_n_r;
      end
    endcase
    steal    = !hit_f_r && !idle_f_r;
    sel_lane = hit_f_r ? hit_l_r : (idle_f_r ? idle_l_r : st_lane);
    lane_ext = 8'(sel_lane);
  end

  always_comb begin
    seen = 1'b0;
    for (int k = LANES - 1; k >= 0; k--) begin
      seen     = seen | (rec_r[k] == sel_lane);
      shift[k] = seen;
    end
    rec_nxt[0] = sel_lane;
    for (int k = 1; k < LANES; k++) begin
      rec_nxt[k] = shift[k] ? rec_r[k-1] : rec_r[k];
    end
  end

  always_comb begin
    res_lane   = '0;
    res_act    = sva_pkg::ACT_NONE;
    res_mask   = '0;
    res_note   = '0;
    res_vel    = '0;
    res_stolen = 1'b0;
    res_snote  = '0;
    case (mode_r)
      sva_pkg::MODE_ON: begin
        res_lane = lane_ext[2:0];
        res_act  = sva_pkg::ACT_TRIG;
        res_note = note_r;
        res_vel  = vel_r;
        if (steal && st_note != sva_pkg::NO_NOTE) begin
          res_stolen = 1'b1;
          res_snote  = st_note[6:0];
        end
      end
      sva_pkg::MODE_OFF: begin
        if (hit_f_r) begin
          res_lane = lane_ext[2:0];
          res_act  = sva_pkg::ACT_REL;
          res_note = note_r;
        end
      end
      sva_pkg::MODE_ALL: begin
        res_act  = sva_pkg::ACT_MASK;
        res_mask = busy_r & LANE_MASK;
      end
      default: begin
        res_act = sva_pkg::ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        lane_note_r[i] <= sva_pkg::NO_NOTE;
        rec_r[i]       <= LW'(i);
      end
      rot_r    <= '0;
      policy_r <= sva_pkg::POL_OLDEST;
    end else begin
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      if (cmd.commit && mode_r == sva_pkg::MODE_ON) begin
        lane_note_r[sel_lane] <= {1'b0, note_r};
        for (int k = 0; k < LANES; k++) begin
          rec_r[k] <= rec_nxt[k];
        end
        if (steal && policy_r == sva_pkg::POL_ROUND) begin
          rot_r <= cand_l_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_tuser;
      note_r   <= in_tdata[6:0];
      vel_r    <= in_tdata[13:7];
      busy_r   <= in_tdata[21:14];
      idx_r    <= '0;
      hit_f_r  <= 1'b0;
      idle_f_r <= 1'b0;
      lo_f_r   <= 1'b0;
      hi_f_r   <= 1'b0;
      lo_t_r   <= sva_pkg::TOP_NOTE;
      hi_t_r   <= '0;
      cand_l_r <= (policy_r == sva_pkg::POL_ROUND) ? rot_inc : rec_r[LANES-1];
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      if (!hit_f_r && cur_note == {1'b0, note_r}) begin
        hit_f_r <= 1'b1;
        hit_l_r <= idx_r;
      end
      if (!idle_f_r && !cur_busy) begin
        idle_f_r <= 1'b1;
        idle_l_r <= idx_r;
      end
      if (cur_note != sva_pkg::NO_NOTE && cur_note[6:0] <= lo_t_r) begin
        lo_f_r <= 1'b1;
        lo_l_r <= idx_r;
        lo_t_r <= cur_note[6:0];
      end
      if (cur_note != sva_pkg::NO_NOTE && cur_note[6:0] >= hi_t_r) begin
        hi_f_r <= 1'b1;
        hi_l_r <= idx_r;
        hi_t_r <= cur_note[6:0];
      end
      if (idx_r == cand_l_r) begin
        cand_n_r <= cur_note;
      end
    end
    if (cmd.commit) begin
      out_data_r <= {7'd0, res_snote, res_stolen, res_vel, res_note, res_mask, res_lane};
      out_user_r <= res_act;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

### rtl/synth_voice_allocator.sv
// Top level of the synthesizer voice allocator.
// A result is registered in the commit state, after the input load and the scan of every lane.
// The scan visits one lane per cycle; a new event is taken only in the idle state, once the last one is committed.
// A new event is taken while the previous result still waits on the output.
// Reset is synchronous: lanes hold no note, the recency order is lane order,
// the rotation pointer is 0 and the steal policy is oldest used lane.
module synth_voice_allocator #(
  parameter int LANES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,    // steal_policy
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // note, velocity, busy_mask, zero pad
  input  logic [1:0]  in_tuser,     // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // lane, release_mask, note_out, velocity_out,
                                    // stolen, stolen_note, zero pad
  output logic [1:0]  out_tuser     // action
);

  sva_pkg::sva_cmd_t cmd;
  sva_pkg::sva_sts_t sts;

  sva_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sva_dp #(
    .LANES (LANES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken again while an event is in work.");

  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sva_pkg::ACT_NONE |-> out_tdata == '0)
    else $error("Result without action carries nonzero fields.");

  a_steal_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != sva_pkg::ACT_TRIG |-> !out_tdata[25])
    else $error("Steal flagged on a result that is no trigger.");

  a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("Result appeared without a committed event.");

endmodule
